>>> rtl/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

	// Request codes
	localparam logic [1:0] OP_ARM    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_FREE   = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_ARM    = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_FIRE   = 2'd2;
	localparam logic [1:0] KIND_FREE   = 2'd3;

	localparam logic [15:0] ID_NONE = 16'hFFFF;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] reload;
		logic [31:0] counter;
	} entry_t;

	typedef struct packed {
		logic        vld;
		logic [1:0]  kind;
		logic        ok;
		logic [15:0] id;
		logic        last;
	} res_t;

endpackage

>>> rtl/ptt_ram.sv
`timescale 1ns / 1ps

module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/ptt_ctrl.sv
`timescale 1ns / 1ps

module ptt_ctrl #(
	parameter int MAX_TIMERS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           opcode,
	input  logic [15:0]          timer_id,
	input  logic [31:0]          period_ticks,
	output logic                 rd_en,
	output logic [((MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1)-1:0] rd_addr,
	input  ptt_pkg::entry_t      rd_data,
	output logic                 wr_en,
	output logic [((MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1)-1:0] wr_addr,
	output ptt_pkg::entry_t      wr_data,
	output ptt_pkg::res_t        res
);

	import ptt_pkg::*;

	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_TIMERS);
	localparam logic [15:0]   MaxId  = 16'(MAX_TIMERS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_FREE  = 2'd3;

	logic [1:0]            st_q;
	logic [1:0]            op_q;
	logic [15:0]           id_q;
	logic [31:0]           ticks_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         rd_q;
	logic                  vld_s1;
	logic [IW-1:0]         idx_s1;
	logic                  hit_q;
	logic [IW-1:0]         slot_q;
	logic                  pend_q;
	logic [15:0]           pend_id_q;
	logic [MAX_TIMERS-1:0] used_q;
	logic [CW-1:0]         cand_q;

	logic walking;
	logic rd_go;
	logic walk_end;
	logic arm_ok;
	logic fire;

	assign busy     = (st_q != ST_IDLE);
	assign walking  = (st_q == ST_SCAN) || (st_q == ST_SHIFT);
	assign rd_go    = walking && (rd_q < cnt_q);
	assign walk_end = walking && !rd_go && !vld_s1;
	assign arm_ok   = !hit_q && (cnt_q < MaxCnt);
	assign fire     = (rd_data.counter == 32'd0);

	assign rd_en   = rd_go;
	assign rd_addr = rd_q[IW-1:0];

	// Memory write port: tick write-back, arm append, cancel shift-down
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data;
		if (st_q == ST_SCAN && vld_s1 && op_q == OP_TICK) begin
			wr_en           = 1'b1;
			wr_data.counter = fire ? rd_data.reload : rd_data.counter - 32'd1;
		end else if (st_q == ST_SCAN && walk_end && op_q == OP_ARM && arm_ok) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[IW-1:0];
			wr_data = '{id: id_q, reload: ticks_q, counter: ticks_q};
		end else if (st_q == ST_SHIFT && vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - IW'(1);
		end
	end

	// Result request; each firing is held back until the next one is found, so the final one can carry last
	always_comb begin
		res = '0;
		case (st_q)
			ST_SCAN: begin
				if (vld_s1 && op_q == OP_TICK && fire && pend_q) begin
					res = '{vld: 1'b1, kind: KIND_FIRE, ok: 1'b1, id: pend_id_q, last: 1'b0};
				end else if (walk_end) begin
					case (op_q)
						OP_ARM: begin
							res = '{vld: 1'b1, kind: KIND_ARM, ok: arm_ok, id: id_q, last: 1'b1};
						end
						OP_CANCEL: begin
							if (!hit_q) begin
								res = '{vld: 1'b1, kind: KIND_CANCEL, ok: 1'b0, id: id_q,
									last: 1'b1};
							end
						end
						OP_TICK: begin
							if (pend_q) begin
								res = '{vld: 1'b1, kind: KIND_FIRE, ok: 1'b1, id: pend_id_q,
									last: 1'b1};
							end
						end
						default: begin
							res = '0;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				if (walk_end) begin
					res = '{vld: 1'b1, kind: KIND_CANCEL, ok: 1'b1, id: id_q, last: 1'b1};
				end
			end
			ST_FREE: begin
				if (cand_q == MaxCnt) begin
					res = '{vld: 1'b1, kind: KIND_FREE, ok: 1'b0, id: ID_NONE, last: 1'b1};
				end else if (!used_q[cand_q[IW-1:0]]) begin
					res = '{vld: 1'b1, kind: KIND_FREE, ok: 1'b1, id: 16'(cand_q), last: 1'b1};
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (start) begin
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= rd_go;
					if (walk_end) begin
						case (op_q)
							OP_ARM: begin
								if (arm_ok) begin
									cnt_q <= cnt_q + CW'(1);
								end
								st_q <= ST_IDLE;
							end
							OP_CANCEL: begin
								st_q <= hit_q ? ST_SHIFT : ST_IDLE;
							end
							OP_TICK: begin
								st_q <= ST_IDLE;
							end
							default: begin
								st_q <= ST_FREE;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					vld_s1 <= rd_go;
					if (walk_end) begin
						cnt_q <= cnt_q - CW'(1);
						st_q  <= ST_IDLE;
					end
				end
				ST_FREE: begin
					if (res.vld) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields and walk bookkeeping
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			op_q    <= opcode;
			id_q    <= timer_id;
			ticks_q <= period_ticks;
			rd_q    <= '0;
			hit_q   <= 1'b0;
			pend_q  <= 1'b0;
			used_q  <= '0;
		end
		if (rd_go) begin
			rd_q <= rd_q + CW'(1);
		end
		idx_s1 <= rd_q[IW-1:0];
		if (st_q == ST_SCAN && vld_s1) begin
			case (op_q)
				OP_ARM, OP_CANCEL: begin
					if (rd_data.id == id_q) begin
						hit_q  <= 1'b1;
						slot_q <= idx_s1;
					end
				end
				OP_TICK: begin
					if (fire) begin
						pend_q    <= 1'b1;
						pend_id_q <= rd_data.id;
					end
				end
				default: begin
					if (rd_data.id < MaxId) begin
						used_q[rd_data.id[IW-1:0]] <= 1'b1;
					end
				end
			endcase
		end
		if (st_q == ST_SCAN && walk_end) begin
			// restart the walk just past the removed entry
			rd_q   <= CW'(slot_q) + CW'(1);
			cand_q <= CW'(1);
		end
		if (st_q == ST_FREE) begin
			cand_q <= cand_q + CW'(1);
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MaxCnt)
		else $error("entry count beyond table size");
	a_wr_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> walking)
		else $error("table write outside a walk");
	a_fire_tick: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld && res.kind == KIND_FIRE |-> op_q == OP_TICK)
		else $error("firing reported for a non-tick request");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld && res.last |=> st_q == ST_IDLE)
		else $error("sequencer still busy after final result");
	a_pipe_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> walking)
		else $error("read data pending outside a walk");
`endif

endmodule

>>> rtl/periodic_timer_table_top.sv
`timescale 1ns / 1ps

// Periodic timer table: up to MAX_TIMERS timers kept in arming order.
// Request channel: drive opcode, timer_id and period_ticks with start high;
// the request is taken at a rising edge where busy is low. Arm appends a
// timer, cancel removes one (later entries move down), tick counts every
// timer down and reports and reloads each one already at zero, find-free reports the
// lowest unused id from 1 to MAX_TIMERS-1.
// Result channel: each result shows for exactly one cycle with result_valid
// high; last marks the final result of a request. There is no back-pressure.
// Arm, tick and find-free walk the table once, and find-free then tests
// candidate ids in turn; cancel walks the table and then, on a hit, moves
// the tail down. Tick's firings appear during the walk. All timer state
// sits in one single-port-read memory, read one entry per cycle during a
// walk; one request is in flight at a time.
// Reset empties the table and drops any result in flight.

module periodic_timer_table_top #(
	parameter int MAX_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] timer_id,
	input  logic [31:0] period_ticks,
	output logic        result_valid,
	output logic [1:0]  kind,
	output logic        ok,
	output logic [15:0] result_id,
	output logic        last
);

	import ptt_pkg::*;

	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	entry_t        rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	res_t          res;
	res_t          res_q;

	// Sequencer: walks the table, modifies and writes back entries
	ptt_ctrl #(
		.MAX_TIMERS(MAX_TIMERS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.timer_id    (timer_id),
		.period_ticks(period_ticks),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.res         (res)
	);

	// Timer entries: id, reload and counter in one word
	ptt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_TIMERS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Hold each result for one cycle in the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res;
		end
	end

	assign result_valid = res_q.vld;
	assign kind         = res_q.kind;
	assign ok           = res_q.ok;
	assign result_id    = res_q.id;
	assign last         = res_q.last;

endmodule

>>> bench/ptt_checker.sv
`timescale 1ns / 1ps

module ptt_checker #(
	parameter int MAX_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] timer_id,
	input  logic [31:0] period_ticks,
	input  logic        result_valid,
	input  logic [1:0]  kind,
	input  logic        ok,
	input  logic [15:0] result_id,
	input  logic        last,
	output int          errors,
	output int          outstanding,
	output int          requests_seen,
	output int          results_seen,
	output int          firings_seen
);

	import ptt_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic        ok;
		logic [15:0] id;
		logic        last;
	} answer_t;

	// Shadow copy of the timer table, in arming order
	logic [15:0] slot_id     [MAX_TIMERS];
	logic [31:0] slot_reload [MAX_TIMERS];
	logic [31:0] slot_count  [MAX_TIMERS];
	int          armed;

	answer_t     expected_answers[$];
	int          mismatch_count = 0;
	int          pending_count  = 0;
	int          request_count  = 0;
	int          result_count   = 0;
	int          fire_count     = 0;

	assign errors        = mismatch_count;
	assign outstanding   = pending_count;
	assign requests_seen = request_count;
	assign results_seen  = result_count;
	assign firings_seen  = fire_count;

	function automatic int find_timer(input logic [15:0] id);
		for (int i = 0; i < armed; i++)
			if (slot_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void push_answer(input logic [1:0] k, input logic good,
			input logic [15:0] id, input logic fin);
		expected_answers.push_back(answer_t'{k, good, id, fin});
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 40)
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Advance the shadow table by one request and queue the answers it causes
	task automatic predict_request(input logic [1:0] op, input logic [15:0] id,
			input logic [31:0] per);
		int          slot;
		int          free_id;
		logic [15:0] fired_ids[$];
		slot = find_timer(id);
		free_id = -1;
		case (op)
			OP_ARM: begin
				if (armed < MAX_TIMERS && slot < 0) begin
					slot_id[armed] = id;
					slot_reload[armed] = per;
					slot_count[armed] = per;
					armed++;
					push_answer(KIND_ARM, 1'b1, id, 1'b1);
				end else begin
					push_answer(KIND_ARM, 1'b0, id, 1'b1);
				end
			end
			OP_CANCEL: begin
				if (slot >= 0) begin
					for (int i = slot; i < armed - 1; i++) begin
						slot_id[i] = slot_id[i + 1];
						slot_reload[i] = slot_reload[i + 1];
						slot_count[i] = slot_count[i + 1];
					end
					armed--;
				end
				push_answer(KIND_CANCEL, slot >= 0, id, 1'b1);
			end
			OP_TICK: begin
				for (int i = 0; i < armed; i++) begin
					if (slot_count[i] == 32'd0) begin
						slot_count[i] = slot_reload[i];
						fired_ids.push_back(slot_id[i]);
					end else begin
						slot_count[i]--;
					end
				end
				foreach (fired_ids[j])
					push_answer(KIND_FIRE, 1'b1, fired_ids[j], j == fired_ids.size() - 1);
			end
			default: begin
				for (int i = 1; i < MAX_TIMERS && free_id < 0; i++)
					if (find_timer(16'(i)) < 0)
						free_id = i;
				if (free_id > 0)
					push_answer(KIND_FREE, 1'b1, 16'(free_id), 1'b1);
				else
					push_answer(KIND_FREE, 1'b0, ID_NONE, 1'b1);
			end
		endcase
	endtask

	// Results of an earlier request are compared before a new request is taken
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			armed = 0;
			expected_answers.delete();
			pending_count = 0;
		end else begin
			if (result_valid) begin
				result_count++;
				if (kind == KIND_FIRE)
					fire_count++;
				if (expected_answers.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 40)
						$display("%0t ns: stray result, expected none, got %0d/%0d/%0d/%0d",
							$time, kind, ok, result_id, last);
				end else begin
					want = expected_answers.pop_front();
					check_field("kind", want.kind, kind);
					check_field("ok", want.ok, ok);
					check_field("result_id", want.id, result_id);
					check_field("last", want.last, last);
				end
			end
			if (start && !busy) begin
				request_count++;
				predict_request(opcode, timer_id, period_ticks);
			end
			pending_count = expected_answers.size();
		end
	end

endmodule

>>> bench/tb_periodic_timer_table_top.sv
`timescale 1ns / 1ps

module tb_periodic_timer_table_top;
	import ptt_pkg::*;

	localparam int MAX_TIMERS   = 16;
	// The limit leaves room for ~410 requests with long sender gaps many
	// times over.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS  = 96;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [15:0] timer_id;
	logic [31:0] period_ticks;
	logic        result_valid;
	logic [1:0]  kind;
	logic        ok;
	logic [15:0] result_id;
	logic        last;

	int errors;
	int outstanding;
	int requests_seen;
	int results_seen;
	int firings_seen;
	int cycle_count = 0;
	int idle_pct = 0;

	periodic_timer_table_top #(
		.MAX_TIMERS(MAX_TIMERS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.timer_id(timer_id),
		.period_ticks(period_ticks),
		.result_valid(result_valid),
		.kind(kind),
		.ok(ok),
		.result_id(result_id),
		.last(last)
	);

	// Watch both channels, predict every answer and compare
	ptt_checker #(
		.MAX_TIMERS(MAX_TIMERS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.timer_id(timer_id),
		.period_ticks(period_ticks),
		.result_valid(result_valid),
		.kind(kind),
		.ok(ok),
		.result_id(result_id),
		.last(last),
		.errors(errors),
		.outstanding(outstanding),
		.requests_seen(requests_seen),
		.results_seen(results_seen),
		.firings_seen(firings_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers still owed", cycle_count, outstanding);
			$display("tb: failure");
			$finish;
		end
	end

	// Drive one request: idle first at the current rate (fields carry junk while
	// start is low), then hold start until a rising edge sees busy low.
	// Returns right after the edge that took the request.
	task automatic send_req(input logic [1:0] op, input logic [15:0] id,
			input logic [31:0] per);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			opcode <= 2'($urandom);
			timer_id <= 16'($urandom);
			period_ticks <= $urandom;
			@(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		timer_id <= id;
		period_ticks <= per;
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		logic [1:0]  op;
		logic [15:0] id;
		logic [31:0] per;
		int          pick;

		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_TICK;
		timer_id = '0;
		period_ticks = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table answers first
		send_req(OP_FREE, 16'd0, 32'd0);
		send_req(OP_CANCEL, 16'd0, 32'd0);
		send_req(OP_TICK, 16'd0, 32'd0);
		// Id zero is a normal id; a second arm of it is refused
		send_req(OP_ARM, 16'd0, 32'd0);
		send_req(OP_ARM, 16'd0, 32'd7);
		// Extremes of id and period; the period-zero timer fires on every tick
		send_req(OP_ARM, 16'hFFFF, 32'hFFFF_FFFF);
		send_req(OP_TICK, 16'd0, 32'd0);
		// Fill the table, then hit it when full
		for (int i = 1; i <= 14; i++)
			send_req(OP_ARM, 16'(i), 32'd0);
		send_req(OP_ARM, 16'd15, 32'h5555_AAAA);
		send_req(OP_FREE, 16'd0, 32'd0);
		// Drop the all-ones timer from the middle, take id 15, and leave no free id
		send_req(OP_CANCEL, 16'hFFFF, 32'd0);
		send_req(OP_ARM, 16'd15, 32'd0);
		send_req(OP_FREE, 16'd0, 32'd0);
		// Every timer sits at zero: a full burst of firings
		send_req(OP_TICK, 16'd0, 32'd0);

		// Random phases: no idling, sender idle 66%, no idling again (the result
		// side has no stall to exercise), sender idle 14%
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 66 : (ph == 3) ? 14 : 0;
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 35)
					op = OP_ARM;
				else if (pick < 60)
					op = OP_CANCEL;
				else if (pick < 90)
					op = OP_TICK;
				else
					op = OP_FREE;
				// Mostly a small pool of ids so arms collide and cancels hit
				pick = $urandom_range(99);
				id = (pick < 85) ? 16'($urandom_range(17)) : 16'($urandom);
				// Mostly short periods so timers fire often
				pick = $urandom_range(99);
				if (pick < 70)
					per = $urandom_range(4);
				else if (pick < 90)
					per = $urandom_range(40);
				else
					per = $urandom;
				send_req(op, id, per);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		// Wait out every owed answer, then give a tick with no firings time to end
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("summary: %0d requests taken, %0d results checked, %0d of them timer firings",
			requests_seen, results_seen, firings_seen);
		$display("summary: %0d field mismatches in %0d cycles", errors, cycle_count);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
